// ===== hdl/btps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package btps_pkg;

  // Field widths.
  localparam int COORD_W = 24;
  localparam int DIR_W   = 16;
  localparam int IDX_W   = 6;
  localparam int LEN_W   = 24;
  localparam int SEG_W   = 6;

  // Segment count limits and reset value.
  localparam int MAX_SEGMENTS = 63;
  localparam logic [SEG_W-1:0] SEG_RESET = 6'd16;

  // Widened control points after the handle offsets are applied.
  localparam int CTRL_W = 26;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 27;
  localparam int PROD_W = 2 * MUL_W;

  // Divider: quotient bits produced, divisor width, dividend width.
  localparam int DIVQ_W = 27;
  localparam int DIVD_W = 19;
  localparam int DIVN_W = 44;

  // Square root: radicand and root widths.
  localparam int RAD_W  = 50;
  localparam int ROOT_W = 25;

  // Weight width (n cubed fits in 18 bits).
  localparam int W_W = 18;

  // Bezier accumulator width.
  localparam int ACC_W = 45;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Rounding constant for the Q.14 direction products.
  localparam int DIR_FRAC = 14;

  // Register addresses (word index).
  localparam logic REG_SEGMENTS = 1'b0;

endpackage

`default_nettype wire

// ===== hdl/bezier_turn_path_sampler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cubic Bezier turn-path sampler.
// A request on the in_ channel carries a start point, an entry direction, an
// end point and an exit direction. The block builds the two control points
// with a handle of 0.4 times the chord length and returns segments+1 samples
// on the out_ channel, each with its index, the running chord-sum arc length
// and a last flag. The segments register sits at address 0 of the APB-style
// port; a value of 0 acts as 1.
// All arithmetic runs in turn through one multiplier, one restoring divider
// (one quotient bit a cycle) and one square-root unit (one root bit a cycle).
// The two divisions and the square root of every sample take up most of the
// time that a request spends in the block.
// in_stall is high from the accepted request until the last sample has been
// placed in the output register. A stalled receiver holds the sequencer only
// when a finished sample finds that register still full, and a new request
// may be accepted while the last sample still waits to be taken.
// A synchronous reset returns the sequencer to idle, empties the output
// register and sets segments to 16.
module bezier_turn_path_sampler_unit
  import btps_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire signed [COORD_W-1:0]  in_start_x,
  input  wire signed [COORD_W-1:0]  in_start_y,
  input  wire signed [DIR_W-1:0]    in_entry_dir_x,
  input  wire signed [DIR_W-1:0]    in_entry_dir_y,
  input  wire signed [COORD_W-1:0]  in_end_x,
  input  wire signed [COORD_W-1:0]  in_end_y,
  input  wire signed [DIR_W-1:0]    in_exit_dir_x,
  input  wire signed [DIR_W-1:0]    in_exit_dir_y,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic [IDX_W-1:0]          out_point_index,
  output logic [LEN_W-1:0]          out_arc_length,
  output logic                      out_last_point,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire [2:0]                 paddr,
  input  wire [31:0]                pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DX   = 4'd1;
  localparam logic [3:0] S_DY   = 4'd2;
  localparam logic [3:0] S_SQL  = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_HL   = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_OFF  = 4'd7;
  localparam logic [3:0] S_WGT  = 4'd8;
  localparam logic [3:0] S_MAC  = 4'd9;
  localparam logic [3:0] S_DLD  = 4'd10;
  localparam logic [3:0] S_ARC  = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;
  localparam logic [3:0] S_HQ   = 4'd13;

  // What the divider result is for.
  localparam logic [1:0] DS_X = 2'd1;
  localparam logic [1:0] DS_Y = 2'd2;

  // What the distance result is for.
  localparam logic DD_CHORD = 1'b0;
  localparam logic DD_ARC   = 1'b1;

  localparam logic [4:0] DIV_LAST = 5'(DIVQ_W - 1);
  localparam logic [4:0] SQ_LAST  = 5'(ROOT_W - 1);

  // Reciprocal of 5 scaled by 2^28 and rounded up; exact for numerators
  // below 2^26.
  localparam int H_SHIFT = 28;
  localparam logic signed [MUL_W-1:0] H_RECIP = 27'sd53687092;

  // ---------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------
  logic [SEG_W-1:0] seg_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SEGMENTS)) begin
      seg_r <= pwdata[SEG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SEGMENTS) begin
      prdata = {{(32-SEG_W){1'b0}}, seg_r};
    end
  end

  // ---------------------------------------------------------------------
  // Control and datapath registers.
  // ---------------------------------------------------------------------
  logic [3:0]  state_r, state_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [1:0]  div_sel_r;
  logic        dist_sel_r;

  logic [IDX_W-1:0] n_r, i_r;
  logic [W_W-1:0]   n3_r;

  logic signed [COORD_W-1:0] p0x_r, p0y_r, p3x_r, p3y_r;
  logic signed [DIR_W-1:0]   vix_r, viy_r, vox_r, voy_r;
  logic signed [CTRL_W-1:0]  p1x_r, p1y_r, p2x_r, p2y_r;
  logic [LEN_W-1:0]          h_r;

  logic [11:0]    t1_r, t2_r;
  logic [W_W-1:0] w0_r, w1_r, w2_r, w3_r;

  logic signed [ACC_W-1:0]   accx_r, accy_r;
  logic signed [COORD_W-1:0] px_r, py_r, prevx_r, prevy_r;
  logic signed [COORD_W:0]   dax_r, day_r;
  logic [LEN_W-1:0]          arc_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_r;
  logic [RAD_W-1:0]         sq_r;

  logic [DIVQ_W-1:0] div_q_r;
  logic [DIVD_W-1:0] div_rem_r, div_d_r;
  logic              div_neg_r;

  logic [RAD_W-1:0]  rad_r;
  logic [27:0]       rem_r;
  logic [ROOT_W-1:0] root_r;

  logic signed [COORD_W-1:0] opx_r, opy_r;
  logic [IDX_W-1:0]          oidx_r;
  logic [LEN_W-1:0]          oarc_r;
  logic                      olast_r;

  // ---------------------------------------------------------------------
  // Shared arithmetic.
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0] u_val;
  logic [13:0]      t1x3, t2x3;
  logic [W_W-1:0]   w_sel;
  logic signed [CTRL_W-1:0] c_sel;

  // Handle length: round(0.4 * chord) with ties up equals
  // floor((2 * chord + 2) / 5), and the division by 5 is a reciprocal multiply.
  logic [25:0] h_num;
  assign h_num = {root_r, 1'b0} + 26'd2;

  assign u_val = n_r - i_r;
  assign t1x3  = {t1_r, 1'b0} + {2'b00, t1_r};
  assign t2x3  = {t2_r, 1'b0} + {2'b00, t2_r};

  always_comb begin
    case (k_r[1:0])
      2'd0:    w_sel = w0_r;
      2'd1:    w_sel = w1_r;
      2'd2:    w_sel = w2_r;
      default: w_sel = w3_r;
    endcase
    case ({k_r[2], k_r[1:0]})
      3'd0:    c_sel = CTRL_W'(p0x_r);
      3'd1:    c_sel = p1x_r;
      3'd2:    c_sel = p2x_r;
      3'd3:    c_sel = CTRL_W'(p3x_r);
      3'd4:    c_sel = CTRL_W'(p0y_r);
      3'd5:    c_sel = p1y_r;
      3'd6:    c_sel = p2y_r;
      default: c_sel = CTRL_W'(p3y_r);
    endcase
  end

  // Operand selection for the one multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DX: begin
        mul_a = MUL_W'(dax_r);
        mul_b = MUL_W'(dax_r);
      end
      S_DY: begin
        mul_a = MUL_W'(day_r);
        mul_b = MUL_W'(day_r);
      end
      S_HL: begin
        mul_a = $signed({1'b0, h_num});
        mul_b = H_RECIP;
      end
      S_OFF: begin
        case (k_r[1:0])
          2'd0:    mul_a = MUL_W'(vix_r);
          2'd1:    mul_a = MUL_W'(viy_r);
          2'd2:    mul_a = MUL_W'(vox_r);
          default: mul_a = MUL_W'(voy_r);
        endcase
        mul_b = $signed({{(MUL_W-LEN_W){1'b0}}, h_r});
      end
      S_WGT: begin
        case (k_r)
          4'd0: begin
            mul_a = $signed({{(MUL_W-IDX_W){1'b0}}, u_val});
            mul_b = $signed({{(MUL_W-IDX_W){1'b0}}, u_val});
          end
          4'd1: begin
            mul_a = $signed({{(MUL_W-IDX_W){1'b0}}, i_r});
            mul_b = $signed({{(MUL_W-IDX_W){1'b0}}, i_r});
          end
          4'd2: begin
            mul_a = $signed({{(MUL_W-12){1'b0}}, t1_r});
            mul_b = $signed({{(MUL_W-IDX_W){1'b0}}, u_val});
          end
          4'd3: begin
            mul_a = $signed({{(MUL_W-12){1'b0}}, t2_r});
            mul_b = $signed({{(MUL_W-IDX_W){1'b0}}, i_r});
          end
          4'd4: begin
            mul_a = $signed({{(MUL_W-14){1'b0}}, t1x3});
            mul_b = $signed({{(MUL_W-IDX_W){1'b0}}, i_r});
          end
          4'd5: begin
            mul_a = $signed({{(MUL_W-14){1'b0}}, t2x3});
            mul_b = $signed({{(MUL_W-IDX_W){1'b0}}, u_val});
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      S_MAC: begin
        mul_a = $signed({{(MUL_W-W_W){1'b0}}, w_sel});
        mul_b = MUL_W'(c_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // Restoring divider step: one quotient bit a cycle.
  logic [DIVD_W:0]   div_trial;
  logic              div_ge;
  logic [DIVD_W-1:0] div_rem_step;
  logic [DIVQ_W-1:0] div_q_step;

  assign div_trial    = {div_rem_r, div_q_r[DIVQ_W-1]};
  assign div_ge       = (div_trial >= {1'b0, div_d_r});
  assign div_rem_step = div_ge ? DIVD_W'(div_trial - {1'b0, div_d_r})
                               : div_trial[DIVD_W-1:0];
  assign div_q_step   = {div_q_r[DIVQ_W-2:0], div_ge};

  // Floor of the signed quotient, then saturation to the coordinate range.
  logic signed [DIVQ_W:0]    div_res;
  logic signed [COORD_W-1:0] div_sat;

  assign div_res = div_neg_r ? $signed(~{1'b0, div_q_step})
                             : $signed({1'b0, div_q_step});

  always_comb begin
    if (div_res > $signed((DIVQ_W+1)'(2**(COORD_W-1) - 1))) begin
      div_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (div_res < -$signed((DIVQ_W+1)'(2**(COORD_W-1)))) begin
      div_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      div_sat = div_res[COORD_W-1:0];
    end
  end

  // Divider load from an accumulator: b = 2*acc + n^3, floor(b / 2n^3).
  logic signed [ACC_W-1:0] acc_sel;
  logic signed [ACC_W:0]   b_val;
  logic [ACC_W:0]          b_mag;

  assign acc_sel = (div_sel_r == DS_X) ? accx_r : accy_r;
  assign b_val   = {acc_sel, 1'b0} + $signed({{(ACC_W+1-W_W){1'b0}}, n3_r});
  assign b_mag   = b_val[ACC_W] ? ~b_val : b_val;

  // Square-root step: one root bit a cycle.
  logic [27:0]       sq_sh, sq_trial;
  logic              sq_ge;

  assign sq_sh    = {rem_r[25:0], rad_r[RAD_W-1:RAD_W-2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  // Handle offset: round(prod / 2^14), ties toward +inf.
  logic signed [PROD_W-1:0] off_full;
  logic signed [CTRL_W-1:0] off_val;

  assign off_full = (mul_r + PROD_W'(2**(DIR_FRAC-1))) >>> DIR_FRAC;
  assign off_val  = off_full[CTRL_W-1:0];

  logic [LEN_W+1:0] arc_sum;
  assign arc_sum = {2'b00, arc_r} + {1'b0, root_r};

  // Effective segment count.
  logic [IDX_W-1:0] n_eff;
  always_comb begin
    if (seg_r == '0) begin
      n_eff = IDX_W'(1);
    end else if (seg_r > SEG_W'(MAX_SEGMENTS)) begin
      n_eff = IDX_W'(MAX_SEGMENTS);
    end else begin
      n_eff = seg_r;
    end
  end

  logic in_fire, emit_fire;
  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DX;
        end
      end
      S_DX:  state_nxt = S_DY;
      S_DY:  state_nxt = S_SQL;
      S_SQL: begin
        state_nxt = S_SQ;
        cnt_nxt   = '0;
      end
      S_SQ: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == SQ_LAST) begin
          state_nxt = (dist_sel_r == DD_CHORD) ? S_HL : S_ARC;
        end
      end
      S_HL:  state_nxt = S_HQ;
      S_HQ: begin
        state_nxt = S_OFF;
        k_nxt     = '0;
      end
      S_DLD: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          case (div_sel_r)
            DS_X:    state_nxt = S_DLD;
            default: state_nxt = (i_r == '0) ? S_EMIT : S_DX;
          endcase
          k_nxt = '0;
        end
      end
      S_OFF: begin
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd4) begin
          state_nxt = S_WGT;
          k_nxt     = '0;
        end
      end
      S_WGT: begin
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd6) begin
          state_nxt = S_MAC;
          k_nxt     = '0;
        end
      end
      S_MAC: begin
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd8) begin
          state_nxt = S_DLD;
          k_nxt     = '0;
        end
      end
      S_ARC: state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt = 1'b1;
          k_nxt         = '0;
          state_nxt     = (i_r == n_r) ? S_IDLE : S_WGT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          p0x_r      <= in_start_x;
          p0y_r      <= in_start_y;
          p3x_r      <= in_end_x;
          p3y_r      <= in_end_y;
          vix_r      <= in_entry_dir_x;
          viy_r      <= in_entry_dir_y;
          vox_r      <= in_exit_dir_x;
          voy_r      <= in_exit_dir_y;
          n_r        <= n_eff;
          i_r        <= '0;
          arc_r      <= '0;
          dist_sel_r <= DD_CHORD;
          dax_r      <= (COORD_W+1)'(in_end_x) - (COORD_W+1)'(in_start_x);
          day_r      <= (COORD_W+1)'(in_end_y) - (COORD_W+1)'(in_start_y);
        end
      end
      S_DY: begin
        sq_r <= mul_r[RAD_W-1:0];
      end
      S_SQL: begin
        rad_r  <= sq_r + mul_r[RAD_W-1:0];
        rem_r  <= '0;
        root_r <= '0;
      end
      S_SQ: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
        root_r <= {root_r[ROOT_W-2:0], sq_ge};
      end
      S_HQ: begin
        h_r <= mul_r[H_SHIFT +: LEN_W];
      end
      S_DLD: begin
        div_neg_r <= b_val[ACC_W];
        div_rem_r <= DIVD_W'(b_mag[DIVN_W-1:DIVQ_W]);
        div_q_r   <= b_mag[DIVQ_W-1:0];
        div_d_r   <= {n3_r, 1'b0};
      end
      S_DIV: begin
        div_rem_r <= div_rem_step;
        div_q_r   <= div_q_step;
        if (cnt_r == DIV_LAST) begin
          case (div_sel_r)
            DS_X: begin
              px_r      <= div_sat;
              div_sel_r <= DS_Y;
            end
            default: begin
              py_r       <= div_sat;
              dist_sel_r <= DD_ARC;
              dax_r      <= (COORD_W+1)'(px_r) - (COORD_W+1)'(prevx_r);
              day_r      <= (COORD_W+1)'(div_sat) - (COORD_W+1)'(prevy_r);
            end
          endcase
        end
      end
      S_OFF: begin
        // The product of direction k-1 is registered and arrives in the cycle after it is issued.
        case (k_r)
          4'd1:    p1x_r <= CTRL_W'(p0x_r) + off_val;
          4'd2:    p1y_r <= CTRL_W'(p0y_r) + off_val;
          4'd3:    p2x_r <= CTRL_W'(p3x_r) - off_val;
          4'd4:    p2y_r <= CTRL_W'(p3y_r) - off_val;
          default: ;
        endcase
      end
      S_WGT: begin
        case (k_r)
          4'd1: t1_r <= mul_r[11:0];
          4'd2: t2_r <= mul_r[11:0];
          4'd3: begin
            w0_r <= mul_r[W_W-1:0];
            // At the first sample u equals n, so w0 is n cubed.
            if (i_r == '0) begin
              n3_r <= mul_r[W_W-1:0];
            end
          end
          4'd4:    w3_r <= mul_r[W_W-1:0];
          4'd5:    w1_r <= mul_r[W_W-1:0];
          4'd6:    w2_r <= mul_r[W_W-1:0];
          default: ;
        endcase
      end
      S_MAC: begin
        if (k_r != 4'd0) begin
          if (k_r[1:0] == 2'd1) begin
            if (k_r[2] == 1'b0) begin
              accx_r <= mul_r[ACC_W-1:0];
            end else begin
              accy_r <= mul_r[ACC_W-1:0];
            end
          end else if (k_r <= 4'd4) begin
            accx_r <= accx_r + mul_r[ACC_W-1:0];
          end else begin
            accy_r <= accy_r + mul_r[ACC_W-1:0];
          end
        end
        if (k_r == 4'd8) begin
          div_sel_r <= DS_X;
        end
      end
      S_ARC: begin
        arc_r <= (arc_sum > {2'b00, LEN_MAX}) ? LEN_MAX : arc_sum[LEN_W-1:0];
      end
      S_EMIT: begin
        if (emit_fire) begin
          opx_r   <= px_r;
          opy_r   <= py_r;
          oidx_r  <= i_r;
          oarc_r  <= arc_r;
          olast_r <= (i_r == n_r);
          prevx_r <= px_r;
          prevy_r <= py_r;
          i_r     <= i_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_point_x     = opx_r;
  assign out_point_y     = opy_r;
  assign out_point_index = oidx_r;
  assign out_arc_length  = oarc_r;
  assign out_last_point  = olast_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // An accepted request keeps the block busy in the following cycle.
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("block not busy after an accepted request");

  // The first sample of a curve carries no arc length.
  a_first_arc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_point_index == '0)) |-> (out_arc_length == '0))
    else $error("first sample has a non-zero arc length");

  // A finished sample is only placed into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_point_index) && out_valid))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
